### design/interval_max_merge_table_defines.svh
// assertion helpers for the interval table rtl
`ifndef INTERVAL_MAX_MERGE_TABLE_DEFINES_SVH
`define INTERVAL_MAX_MERGE_TABLE_DEFINES_SVH

// property checked on every clock outside reset
`define IMM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition now implies expectation on the next clock
`define IMM_ASSERT_NEXT(lbl, cond, expct, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expct)) \
        else $error(msg);

`endif

### design/imm_pkg.sv
`timescale 1ns / 1ps
package imm_pkg;

    localparam int MAX_INTERVALS_DEF = 32;
    localparam logic signed [63:0] NO_MARK = {1'b1, 63'd0};

    typedef enum logic [1:0] {
        CMD_APPLY  = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_MAX    = 2'd2,
        CMD_SLICE  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic signed [63:0] tok_start;
        logic signed [63:0] tok_end;
        logic signed [63:0] stamp;
        logic signed [31:0] del;
    } t_entry;

    typedef struct packed {
        logic               status;
        logic               found;
        logic signed [63:0] stamp;
        logic signed [31:0] del;
        logic signed [63:0] tok_start;
        logic signed [63:0] tok_end;
        logic               last;
    } t_res;

    // mark a is newer than mark b
    function automatic logic newer(logic signed [63:0] ta, logic signed [31:0] da,
                                   logic signed [63:0] tb, logic signed [31:0] db);
        return (ta > tb) || ((ta == tb) && (da > db));
    endfunction

endpackage

### design/imm_mem.sv
`timescale 1ns / 1ps
module imm_mem #(
    parameter int MAX_INTERVALS = imm_pkg::MAX_INTERVALS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [$clog2(MAX_INTERVALS):0]     i_waddr,
    input  imm_pkg::t_entry                    i_wdata,
    input  logic [$clog2(MAX_INTERVALS):0]     i_raddr,
    output imm_pkg::t_entry                    o_rdata
);
    import imm_pkg::*;

    localparam int AW = $clog2(MAX_INTERVALS) + 1;

    // two banks: live table and rebuild target, selected by the top bit
    t_entry r_mem [2**AW];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/interval_max_merge_table.sv
`timescale 1ns / 1ps
// interval max-merge table
// input channel: i_in_valid / o_in_stall carry one command word (apply, search,
// newest mark or slice) with its tokens and mark; a word is taken when valid is
// high and stall is low, and stall stays high until the command has finished
// output channel: o_out_valid / i_out_stall carry result words; apply, search and
// newest mark give one word, slice gives one word per clipped interval with
// o_last set on the final one (one empty word when nothing overlaps)
// the stored list is walked one entry at a time out of a one-port-read memory;
// search, max and slice read and evaluate each entry visited and then advance, and
// apply takes per stored entry a read, an evaluate, up to four merge pieces and an
// advance, and then flushes the pending entry and swaps banks
// apply rebuilds the list into the spare memory bank and swaps banks only when the
// result fits; on overflow the live bank is untouched and status 1 is returned
// reset clears the entry count and the control state; memory contents are not
// cleared, nothing past the entry count is ever read
// while the receiver stalls, the finished word waits in the output register and
// the block keeps working until it has the next word to hand over
module interval_max_merge_table #(
    parameter int MAX_INTERVALS = imm_pkg::MAX_INTERVALS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_command,
    input  logic signed [63:0]  i_range_start,
    input  logic signed [63:0]  i_range_end,
    input  logic signed [63:0]  i_probe_token,
    input  logic signed [63:0]  i_mark_stamp,
    input  logic signed [31:0]  i_mark_deletion_time,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_status,
    output logic                o_mark_found,
    output logic signed [63:0]  o_out_stamp,
    output logic signed [31:0]  o_out_deletion_time,
    output logic signed [63:0]  o_out_start,
    output logic signed [63:0]  o_out_end,
    output logic                o_last
);
    import imm_pkg::*;

    `include "interval_max_merge_table_defines.svh"

    localparam int IW = $clog2(MAX_INTERVALS);
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_INTERVALS);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_RD    = 14'b00000000000010,
        S_EV    = 14'b00000000000100,
        S_PA    = 14'b00000000001000,
        S_PB    = 14'b00000000010000,
        S_PC    = 14'b00000000100000,
        S_PD    = 14'b00000001000000,
        S_CP    = 14'b00000010000000,
        S_FIN   = 14'b00000100000000,
        S_FLUSH = 14'b00001000000000,
        S_SL    = 14'b00010000000000,
        S_NX    = 14'b00100000000000,
        S_END   = 14'b01000000000000,
        S_PUSH  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state, r_after, n_after;

    // latched command word
    t_cmd               r_cmd;
    logic signed [63:0] r_rs, r_re, r_pt, r_mt;
    logic signed [31:0] r_md;

    // table control
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_bank, n_bank;
    logic [CW-1:0] r_k, n_k;
    t_entry        r_ent, n_ent;
    t_entry        rdata;

    // merge state
    logic signed [63:0] r_cur, n_cur;
    t_entry        r_pend, n_pend;
    logic          r_pv, n_pv;
    logic [CW-1:0] r_nc, n_nc;
    logic          r_ovf, n_ovf;
    logic          r_fd, n_fd;
    logic          r_post, n_post;

    // newest mark and slice hold
    logic signed [63:0] r_bt, n_bt;
    logic signed [31:0] r_bd, n_bd;
    logic          r_bf, n_bf;
    t_entry        r_hold, n_hold;
    logic          r_hv, n_hv;

    // result staging and output register
    t_res          r_res, n_res;
    t_res          r_out;
    logic          r_ov;

    // emit path
    logic          e_v, e_mg, coal, nc_full, mem_we, out_free, flush_ovf;
    t_entry        e_p;
    logic signed [63:0] oe, cs, ce;

    assign out_free = !r_ov || !i_out_stall;
    assign nc_full  = (r_nc == CNT_MAX);
    assign oe       = (r_ent.tok_end < r_re) ? r_ent.tok_end : r_re;
    assign cs       = (r_ent.tok_start < r_rs) ? r_rs : r_ent.tok_start;
    assign ce       = (r_ent.tok_end > r_re) ? r_re : r_ent.tok_end;
    assign flush_ovf = r_ovf || (r_pv && nc_full);

    // candidate piece for the merged list
    always_comb begin
        e_v  = 1'b0;
        e_mg = 1'b1;
        e_p  = r_ent;
        case (r_state)
            S_PA: begin
                e_v = r_ent.tok_start < r_cur;
                e_p.tok_end = (r_ent.tok_end < r_cur) ? r_ent.tok_end : r_cur;
            end
            S_PB: begin
                e_v = r_cur < r_ent.tok_start;
                e_p = '{tok_start: r_cur, tok_end: r_ent.tok_start, stamp: r_mt, del: r_md};
            end
            S_PC: begin
                e_v = r_cur < oe;
                e_p.tok_start = r_cur;
                e_p.tok_end   = oe;
                if (newer(r_mt, r_md, r_ent.stamp, r_ent.del)) begin
                    e_p.stamp = r_mt;
                    e_p.del   = r_md;
                end
            end
            S_PD: begin
                e_v = r_re < r_ent.tok_end;
                e_p.tok_start = r_re;
            end
            S_FIN: begin
                e_v = r_cur < r_re;
                e_p = '{tok_start: r_cur, tok_end: r_re, stamp: r_mt, del: r_md};
            end
            S_CP: begin
                e_v  = 1'b1;
                e_mg = 1'b0;
            end
            default: begin
                e_v = 1'b0;
            end
        endcase
    end

    // merged pieces join the pending entry when they touch with equal marks
    assign coal = e_mg && r_pv && (r_pend.tok_end == e_p.tok_start) &&
                  (r_pend.stamp == e_p.stamp) && (r_pend.del == e_p.del);

    assign mem_we = !nc_full && r_pv &&
                    ((e_v && !coal) || (r_state == S_FLUSH));

    imm_mem #(
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr ({~r_bank, r_nc[IW-1:0]}),
        .i_wdata (r_pend),
        .i_raddr ({r_bank, r_k[IW-1:0]}),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        n_after = r_after;
        n_cnt   = r_cnt;
        n_bank  = r_bank;
        n_k     = r_k;
        n_ent   = r_ent;
        n_cur   = r_cur;
        n_pend  = r_pend;
        n_pv    = r_pv;
        n_nc    = r_nc;
        n_ovf   = r_ovf;
        n_fd    = r_fd;
        n_post  = r_post;
        n_bt    = r_bt;
        n_bd    = r_bd;
        n_bf    = r_bf;
        n_hold  = r_hold;
        n_hv    = r_hv;
        n_res   = r_res;

        // pending entry update
        if (e_v) begin
            if (coal) begin
                n_pend.tok_end = e_p.tok_end;
            end else begin
                if (r_pv) begin
                    if (nc_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_nc = r_nc + 1'b1;
                    end
                end
                n_pend = e_p;
                n_pv   = 1'b1;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_k    = '0;
                    n_cur  = i_range_start;
                    n_pv   = 1'b0;
                    n_nc   = '0;
                    n_ovf  = 1'b0;
                    n_fd   = 1'b0;
                    n_post = 1'b0;
                    n_bf   = 1'b0;
                    n_hv   = 1'b0;
                    n_res  = '0;
                    n_res.last = 1'b1;
                    n_after = S_IDLE;
                    if (t_cmd'(i_command) == CMD_APPLY &&
                        (!(i_range_start < i_range_end) || i_mark_stamp == NO_MARK)) begin
                        n_state = S_PUSH;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                if (r_k == r_cnt) begin
                    if (r_cmd == CMD_APPLY) begin
                        n_post  = 1'b0;
                        n_state = r_fd ? S_FLUSH : S_FIN;
                    end else begin
                        n_state = S_END;
                    end
                end else begin
                    n_state = S_EV;
                end
            end
            S_EV: begin
                n_ent = rdata;
                case (r_cmd)
                    CMD_APPLY: begin
                        if (rdata.tok_end < r_rs) begin
                            n_state = S_CP;
                        end else if (rdata.tok_start <= r_re) begin
                            n_state = S_PA;
                        end else if (r_fd) begin
                            n_state = S_CP;
                        end else begin
                            n_post  = 1'b1;
                            n_state = S_FIN;
                        end
                    end
                    CMD_SEARCH: begin
                        if (rdata.tok_end < r_pt) begin
                            n_state = S_NX;
                        end else begin
                            if (rdata.tok_start < r_pt) begin
                                n_res.found = 1'b1;
                                n_res.stamp = rdata.stamp;
                                n_res.del   = rdata.del;
                            end
                            n_state = S_PUSH;
                        end
                    end
                    CMD_MAX: begin
                        if (!r_bf || newer(rdata.stamp, rdata.del, r_bt, r_bd)) begin
                            n_bt = rdata.stamp;
                            n_bd = rdata.del;
                        end
                        n_bf    = 1'b1;
                        n_state = S_NX;
                    end
                    default: begin
                        if (rdata.tok_end < r_rs) begin
                            n_state = S_NX;
                        end else if (r_re <= rdata.tok_start) begin
                            n_state = S_END;
                        end else begin
                            n_state = S_SL;
                        end
                    end
                endcase
            end
            S_PA: begin
                n_state = (r_ent.tok_end <= r_cur) ? S_NX : S_PB;
            end
            S_PB: begin
                if (r_cur < r_ent.tok_start) begin
                    n_cur = r_ent.tok_start;
                end
                n_state = S_PC;
            end
            S_PC: begin
                n_cur   = oe;
                n_state = S_PD;
            end
            S_PD, S_CP: begin
                n_state = S_NX;
            end
            S_FIN: begin
                n_fd    = 1'b1;
                n_state = r_post ? S_CP : S_FLUSH;
            end
            S_FLUSH: begin
                n_res.status = flush_ovf;
                if (!flush_ovf) begin
                    n_bank = ~r_bank;
                    n_cnt  = r_nc + CW'(r_pv);
                end
                n_state = S_PUSH;
            end
            S_SL: begin
                n_state = S_NX;
                if (cs < ce) begin
                    n_hold = '{tok_start: cs, tok_end: ce, stamp: r_ent.stamp, del: r_ent.del};
                    n_hv   = 1'b1;
                    if (r_hv) begin
                        n_res = '{status: 1'b0, found: 1'b1, stamp: r_hold.stamp,
                                  del: r_hold.del, tok_start: r_hold.tok_start,
                                  tok_end: r_hold.tok_end, last: 1'b0};
                        n_after = S_NX;
                        n_state = S_PUSH;
                    end
                end
            end
            S_NX: begin
                n_k     = r_k + 1'b1;
                n_state = S_RD;
            end
            S_END: begin
                n_res = '0;
                n_res.last = 1'b1;
                if (r_cmd == CMD_MAX && r_bf) begin
                    n_res.found = 1'b1;
                    n_res.stamp = r_bt;
                    n_res.del   = r_bd;
                end else if (r_cmd == CMD_SLICE && r_hv) begin
                    n_res = '{status: 1'b0, found: 1'b1, stamp: r_hold.stamp,
                              del: r_hold.del, tok_start: r_hold.tok_start,
                              tok_end: r_hold.tok_end, last: 1'b1};
                end
                n_after = S_IDLE;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (out_free) begin
                    n_state = r_after;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= S_IDLE;
            r_cnt   <= '0;
            r_bank  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_cnt   <= n_cnt;
            r_bank  <= n_bank;
            if (r_state == S_PUSH && out_free) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_cmd <= t_cmd'(i_command);
            r_rs  <= i_range_start;
            r_re  <= i_range_end;
            r_pt  <= i_probe_token;
            r_mt  <= i_mark_stamp;
            r_md  <= i_mark_deletion_time;
        end
        if (r_state == S_PUSH && out_free) begin
            r_out <= r_res;
        end
        r_k    <= n_k;
        r_ent  <= n_ent;
        r_cur  <= n_cur;
        r_pend <= n_pend;
        r_pv   <= n_pv;
        r_nc   <= n_nc;
        r_ovf  <= n_ovf;
        r_fd   <= n_fd;
        r_post <= n_post;
        r_bt   <= n_bt;
        r_bd   <= n_bd;
        r_bf   <= n_bf;
        r_hold <= n_hold;
        r_hv   <= n_hv;
        r_res  <= n_res;
    end

    assign o_in_stall          = (r_state != S_IDLE);
    assign o_out_valid         = r_ov;
    assign o_status            = r_out.status;
    assign o_mark_found        = r_out.found;
    assign o_out_stamp         = r_out.stamp;
    assign o_out_deletion_time = r_out.del;
    assign o_out_start         = r_out.tok_start;
    assign o_out_end           = r_out.tok_end;
    assign o_last              = r_out.last;

    // rebuild count is only meaningful once a command has been taken
    `IMM_ASSERT(a_cnt_range, r_cnt <= CNT_MAX, "entry count beyond table size")
    `IMM_ASSERT(a_nc_range, r_state == S_IDLE || r_nc <= CNT_MAX, "rebuild count beyond table size")
    `IMM_ASSERT_NEXT(a_push_lands, r_state == S_PUSH && out_free, o_out_valid,
        "result word not presented after push")
    `IMM_ASSERT_NEXT(a_swap, r_state == S_FLUSH && !flush_ovf, r_bank != $past(r_bank),
        "bank not swapped after successful apply")

endmodule
